// ===== hw/rtl/ssd_pkg.sv =====
package ssd_pkg;

  localparam int unsigned NumPortsDef    = 2;
  localparam int unsigned RatioWindowDef = 1024;
  localparam int unsigned RatioShiftDef  = 16;
  localparam int unsigned MaxBurstDef    = 16;

  localparam int unsigned PortSlots  = 2;
  localparam int unsigned ResultCap  = 16;
  localparam int unsigned CountW     = 32;
  localparam int unsigned CfgW       = 24;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned DivW       = 33;
  localparam int unsigned DivCntW    = $clog2(DivW);
  localparam int unsigned InDataW    = 136;
  localparam int unsigned OutDataW   = 40;

  typedef enum logic [1:0] {
    ACT_POLL    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_LOAD    = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLOCK_ENABLED     = 3'd0,
    REG_CLOCK_SOURCE      = 3'd1,
    REG_CYCLES_PER_SAMPLE = 3'd2,
    REG_TX_DIVIDER_A      = 3'd3,
    REG_RX_DIVIDER_A      = 3'd4,
    REG_TX_DIVIDER_B      = 3'd5,
    REG_RX_DIVIDER_B      = 3'd6,
    REG_SPARE             = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    EMIT_ZERO,
    EMIT_LOAD,
    EMIT_OFF,
    EMIT_SLOT,
    EMIT_WAIT
  } emit_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHECK,
    ST_SLOT,
    ST_CONV,
    ST_DIV1,
    ST_DIV2,
    ST_MUL,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic  load_item;
    logic  emit;
    emit_e emit_kind;
    logic  emit_last;
    logic  restart_mark;
    logic  load_ctr;
    logic  fix_mark;
    logic  slot_step;
    logic  hold_clear;
    logic  conv_latch;
    logic  div1_start;
    logic  div2_start;
    logic  recip_load;
    logic  mul;
  } ssd_cmd_t;

  typedef struct packed {
    action_e action;
    logic    enabled;
    logic    diff_ge;
    logic    next_ge;
    logic    burst_last;
    logic    src_cycles;
    logic    ratio_due;
    logic    out_free;
    logic    div_busy;
  } ssd_sts_t;

  typedef struct packed {
    logic              fire;
    logic [CountW-1:0] value;
  } cnt_step_t;

  function automatic cnt_step_t count_step(logic [CountW-1:0] ctr, logic [CfgW-1:0] divider);
    cnt_step_t         r;
    logic [CountW-1:0] nxt;
    nxt = ctr + 32'd1;
    if (!nxt[CountW-1] && (nxt[CountW-2:0] > {7'd0, divider})) begin
      r.fire  = 1'b1;
      r.value = '0;
    end else begin
      r.fire  = 1'b0;
      r.value = nxt;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/serial_slot_clock_divider.sv =====
// channel   | direction | handshake                   | content
// s_axis    | in        | s_axis_tvalid/s_axis_tready | poll, restart or load word
// m_axis    | out       | m_axis_tvalid/m_axis_tready | one word per served slot, at least one per word
// cfg       | in        | cfg_valid_i/cfg_ready_o     | register index and value
// a word is taken only while the controller is idle; one word is in work at a time
// restart, load and disabled polls emit from decode; a poll with no slot due ends in emit
// a burst stalls on a held result; a burst cut at the limit ends without the wait step
// in cycle mode a due ratio refresh runs two 33-step divisions
// reset clears marks, port counters and registers, and the ratio to one half
// a stalled result holds the controller at its next emit until m_axis_tready takes it
module serial_slot_clock_divider import ssd_pkg::*; #(
  parameter int unsigned NUM_PORTS    = NumPortsDef,
  parameter int unsigned RATIO_WINDOW = RatioWindowDef,
  parameter int unsigned RATIO_SHIFT  = RatioShiftDef,
  parameter int unsigned MAX_BURST    = MaxBurstDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // instruction_count, cycle_count, tx_enabled_mask, rx_enabled_mask, port_index,
  // tx_counter_value, rx_counter_value, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // action
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tx_fire_mask, rx_fire_mask, wait_instructions, port_found, zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  ssd_cmd_t             cmd;
  ssd_sts_t             sts;
  logic [PortSlots-1:0] tx_fire, rx_fire;
  logic [CountW-1:0]    wait_instr;
  logic                 found;

  assign cfg_ready_o = 1'b1;

  ssd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssd_datapath #(
    .NUM_PORTS    (NUM_PORTS),
    .RATIO_WINDOW (RATIO_WINDOW),
    .RATIO_SHIFT  (RATIO_SHIFT),
    .MAX_BURST    (MAX_BURST)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_valid_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .action_i            (action_e'(s_axis_tuser)),
    .instruction_count_i (s_axis_tdata[31:0]),
    .cycle_count_i       (s_axis_tdata[63:32]),
    .tx_enabled_mask_i   (s_axis_tdata[65:64]),
    .rx_enabled_mask_i   (s_axis_tdata[67:66]),
    .port_index_i        (s_axis_tdata[68]),
    .tx_counter_value_i  (s_axis_tdata[100:69]),
    .rx_counter_value_i  (s_axis_tdata[132:101]),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_ready_i         (m_axis_tready),
    .out_valid_o         (m_axis_tvalid),
    .tx_fire_mask_o      (tx_fire),
    .rx_fire_mask_o      (rx_fire),
    .wait_instructions_o (wait_instr),
    .port_found_o        (found),
    .last_result_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {3'd0, found, wait_instr, rx_fire, tx_fire};

endmodule

// ===== hw/rtl/ssd_divider.sv =====
module ssd_divider import ssd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            busy_o,
  output logic [DivW-1:0] quotient_o
);

  logic [DivW-1:0]    rem_q, rem_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [DivW-1:0]    den_q, den_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [DivW:0]      shifted;
  logic [DivW:0]      trial;

  always_comb begin
    shifted = {rem_q, quo_q[DivW-1]};
    trial   = shifted - {1'b0, den_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
      cnt_d  = DivCntW'(DivW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivW]) begin
        rem_d = trial[DivW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DivW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");

endmodule

// ===== hw/rtl/ssd_datapath.sv =====
module ssd_datapath import ssd_pkg::*; #(
  parameter int unsigned NUM_PORTS    = NumPortsDef,
  parameter int unsigned RATIO_WINDOW = RatioWindowDef,
  parameter int unsigned RATIO_SHIFT  = RatioShiftDef,
  parameter int unsigned MAX_BURST    = MaxBurstDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  input  action_e              action_i,
  input  logic [CountW-1:0]    instruction_count_i,
  input  logic [CountW-1:0]    cycle_count_i,
  input  logic [PortSlots-1:0] tx_enabled_mask_i,
  input  logic [PortSlots-1:0] rx_enabled_mask_i,
  input  logic                 port_index_i,
  input  logic [CountW-1:0]    tx_counter_value_i,
  input  logic [CountW-1:0]    rx_counter_value_i,
  input  ssd_cmd_t             cmd_i,
  output ssd_sts_t             sts_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [PortSlots-1:0] tx_fire_mask_o,
  output logic [PortSlots-1:0] rx_fire_mask_o,
  output logic [CountW-1:0]    wait_instructions_o,
  output logic                 port_found_o,
  output logic                 last_result_o
);

  localparam int unsigned BurstLimit = (MAX_BURST < ResultCap) ? MAX_BURST : ResultCap;
  localparam int unsigned BurstW     = $clog2(BurstLimit + 1);

  logic                 clk_en_q;
  logic                 clk_src_q;
  logic [CfgW-1:0]      cps_q;
  logic [CfgW-1:0]      tx_div_q [PortSlots];
  logic [CfgW-1:0]      rx_div_q [PortSlots];

  action_e              act_q;
  logic [CountW-1:0]    icnt_q, ccnt_q;
  logic [PortSlots-1:0] txen_q, rxen_q;
  logic                 pidx_q;
  logic [CountW-1:0]    txv_q, rxv_q;

  logic [CountW-1:0]    mark_q, mark_d;
  logic [CountW-1:0]    tx_ctr_q [PortSlots];
  logic [CountW-1:0]    tx_ctr_d [PortSlots];
  logic [CountW-1:0]    rx_ctr_q [PortSlots];
  logic [CountW-1:0]    rx_ctr_d [PortSlots];
  logic [CountW-1:0]    rim_q, rcm_q;
  logic [CountW-1:0]    recip_q;
  logic [BurstW-1:0]    n_q;
  logic [PortSlots-1:0] tx_hold_q, rx_hold_q;
  logic [CountW-1:0]    units_q;
  logic [2*CountW-1:0]  prod_q;

  logic                 ov_q;
  logic [PortSlots-1:0] otx_q, orx_q;
  logic [CountW-1:0]    owait_q;
  logic                 ofound_q, olast_q;

  logic [CountW-1:0]    now, diff, next_diff, cps_w, di, dc, conv_wait;
  logic [PortSlots-1:0] tx_fire, rx_fire;
  logic                 port_hit;
  logic [DivW-1:0]      div_a, div_b, div_q;
  logic                 div_busy;
  cnt_step_t            tx_step [PortSlots];
  cnt_step_t            rx_step [PortSlots];

  assign cps_w     = {8'd0, cps_q};
  assign now       = clk_src_q ? ccnt_q : icnt_q;
  assign diff      = now - mark_q;
  assign next_diff = diff - cps_w;
  assign di        = icnt_q - rim_q;
  assign dc        = ccnt_q - rcm_q;
  assign port_hit  = (32'(pidx_q) < 32'(NUM_PORTS)) && (32'(pidx_q) < 32'(PortSlots));
  assign conv_wait = clk_src_q ? 32'(prod_q >> RATIO_SHIFT) : units_q;

  always_comb begin
    for (int p = 0; p < PortSlots; p++) begin
      tx_step[p] = count_step(tx_ctr_q[p], tx_div_q[p]);
      rx_step[p] = count_step(rx_ctr_q[p], rx_div_q[p]);
      tx_fire[p] = (p < NUM_PORTS) && txen_q[p] && tx_step[p].fire;
      rx_fire[p] = (p < NUM_PORTS) && rxen_q[p] && rx_step[p].fire;
    end
  end

  always_comb begin
    mark_d = mark_q;
    if (cmd_i.restart_mark) begin
      mark_d = now;
    end else if (cmd_i.fix_mark && (now < mark_q)) begin
      mark_d = now;
    end else if (cmd_i.slot_step) begin
      mark_d = mark_q + cps_w;
    end
    for (int p = 0; p < PortSlots; p++) begin
      tx_ctr_d[p] = tx_ctr_q[p];
      rx_ctr_d[p] = rx_ctr_q[p];
      if (cmd_i.load_ctr && port_hit && (32'(pidx_q) == 32'(p))) begin
        tx_ctr_d[p] = txv_q;
        rx_ctr_d[p] = rxv_q;
      end else if (cmd_i.slot_step && (p < NUM_PORTS)) begin
        if (txen_q[p]) begin
          tx_ctr_d[p] = tx_step[p].value;
        end
        if (rxen_q[p]) begin
          rx_ctr_d[p] = rx_step[p].value;
        end
      end
    end
  end

  always_comb begin
    div_a = ({1'b0, dc} + {1'b0, di}) - 33'd1;
    div_b = {1'b0, di};
    if (cmd_i.div2_start) begin
      div_a = 33'd1 << RATIO_SHIFT;
      div_b = (div_q == '0) ? 33'd1 : div_q;
    end
  end

  ssd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div1_start | cmd_i.div2_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .quotient_o (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_en_q  <= 1'b0;
      clk_src_q <= 1'b0;
      cps_q     <= '0;
      mark_q    <= '0;
      rim_q     <= '0;
      rcm_q     <= '0;
      recip_q   <= 32'd1 << (RATIO_SHIFT - 1);
      n_q       <= '0;
      ov_q      <= 1'b0;
      for (int p = 0; p < PortSlots; p++) begin
        tx_div_q[p] <= '0;
        rx_div_q[p] <= '0;
        tx_ctr_q[p] <= '0;
        rx_ctr_q[p] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_CLOCK_ENABLED:     clk_en_q    <= cfg_data_i[0];
          REG_CLOCK_SOURCE:      clk_src_q   <= cfg_data_i[0];
          REG_CYCLES_PER_SAMPLE: cps_q       <= cfg_data_i;
          REG_TX_DIVIDER_A:      tx_div_q[0] <= cfg_data_i;
          REG_RX_DIVIDER_A:      rx_div_q[0] <= cfg_data_i;
          REG_TX_DIVIDER_B:      tx_div_q[1] <= cfg_data_i;
          REG_RX_DIVIDER_B:      rx_div_q[1] <= cfg_data_i;
          default: ;
        endcase
      end
      mark_q <= mark_d;
      for (int p = 0; p < PortSlots; p++) begin
        tx_ctr_q[p] <= tx_ctr_d[p];
        rx_ctr_q[p] <= rx_ctr_d[p];
      end
      if (cmd_i.div1_start) begin
        rim_q <= icnt_q;
        rcm_q <= ccnt_q;
      end
      if (cmd_i.recip_load) begin
        recip_q <= div_q[CountW-1:0];
      end
      if (cmd_i.load_item) begin
        n_q <= '0;
      end else if (cmd_i.slot_step) begin
        n_q <= n_q + 1'b1;
      end
      if (cmd_i.emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      act_q  <= action_i;
      icnt_q <= instruction_count_i;
      ccnt_q <= cycle_count_i;
      txen_q <= tx_enabled_mask_i;
      rxen_q <= rx_enabled_mask_i;
      pidx_q <= port_index_i;
      txv_q  <= tx_counter_value_i;
      rxv_q  <= rx_counter_value_i;
    end
    if (cmd_i.hold_clear) begin
      tx_hold_q <= '0;
      rx_hold_q <= '0;
    end else if (cmd_i.slot_step) begin
      tx_hold_q <= tx_fire;
      rx_hold_q <= rx_fire;
    end
    if (cmd_i.conv_latch) begin
      units_q <= cps_w - diff;
    end
    if (cmd_i.mul) begin
      prod_q <= units_q * recip_q;
    end
    if (cmd_i.emit) begin
      otx_q    <= '0;
      orx_q    <= '0;
      owait_q  <= '0;
      ofound_q <= 1'b0;
      olast_q  <= 1'b1;
      case (cmd_i.emit_kind)
        EMIT_LOAD: ofound_q <= port_hit;
        EMIT_OFF:  owait_q  <= '1;
        EMIT_SLOT: begin
          otx_q   <= tx_fire;
          orx_q   <= rx_fire;
          olast_q <= cmd_i.emit_last;
        end
        EMIT_WAIT: begin
          otx_q   <= tx_hold_q;
          orx_q   <= rx_hold_q;
          owait_q <= conv_wait;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts_o.action     = act_q;
    sts_o.enabled    = clk_en_q && (cps_q != '0);
    sts_o.diff_ge    = diff >= cps_w;
    sts_o.next_ge    = next_diff >= cps_w;
    sts_o.burst_last = n_q == BurstW'(BurstLimit - 1);
    sts_o.src_cycles = clk_src_q;
    sts_o.ratio_due  = di >= 32'(RATIO_WINDOW);
    sts_o.out_free   = !ov_q || out_ready_i;
    sts_o.div_busy   = div_busy;
  end

  assign out_valid_o         = ov_q;
  assign tx_fire_mask_o      = otx_q;
  assign rx_fire_mask_o      = orx_q;
  assign wait_instructions_o = owait_q;
  assign port_found_o        = ofound_q;
  assign last_result_o       = olast_q;

endmodule

// ===== hw/rtl/ssd_ctrl.sv =====
module ssd_ctrl import ssd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ssd_sts_t sts_i,
  output ssd_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        if (sts_i.action == ACT_POLL && sts_i.enabled) begin
          state_d = ST_CHECK;
        end else if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_CHECK:  state_d = sts_i.diff_ge ? ST_SLOT : ST_CONV;
      ST_SLOT: begin
        if (sts_i.out_free) begin
          if (!sts_i.next_ge) begin
            state_d = ST_CONV;
          end else if (sts_i.burst_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CONV: begin
        if (!sts_i.src_cycles) begin
          state_d = ST_EMIT;
        end else if (sts_i.ratio_due) begin
          state_d = ST_DIV1;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_DIV1:   if (!sts_i.div_busy) state_d = ST_DIV2;
      ST_DIV2:   if (!sts_i.div_busy) state_d = ST_MUL;
      ST_MUL:    state_d = ST_EMIT;
      ST_EMIT:   if (sts_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.emit_kind = EMIT_ZERO;
    in_ready_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_DECODE: begin
        if (sts_i.action == ACT_POLL && sts_i.enabled) begin
          cmd_o.fix_mark = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          case (sts_i.action)
            ACT_RESTART: cmd_o.restart_mark = 1'b1;
            ACT_LOAD: begin
              cmd_o.load_ctr  = 1'b1;
              cmd_o.emit_kind = EMIT_LOAD;
            end
            ACT_POLL:    cmd_o.emit_kind = EMIT_OFF;
            default: ;
          endcase
        end
      end
      ST_CHECK:  cmd_o.hold_clear = !sts_i.diff_ge;
      ST_SLOT: begin
        if (sts_i.out_free) begin
          cmd_o.slot_step = 1'b1;
          cmd_o.emit      = sts_i.next_ge;
          cmd_o.emit_kind = EMIT_SLOT;
          cmd_o.emit_last = sts_i.burst_last;
        end
      end
      ST_CONV: begin
        cmd_o.conv_latch = 1'b1;
        cmd_o.div1_start = sts_i.src_cycles && sts_i.ratio_due;
      end
      ST_DIV1:   cmd_o.div2_start = !sts_i.div_busy;
      ST_DIV2:   cmd_o.recip_load = !sts_i.div_busy;
      ST_MUL:    cmd_o.mul = 1'b1;
      ST_EMIT: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_kind = EMIT_WAIT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_DECODE) else $error("accept not decoded");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free) else $error("word emitted over a held result");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> !sts_i.div_busy) else $error("multiply before division done");

endmodule
